[rtl/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
// No dependencies; used by ile_cell and indexed_list_engine.
`default_nettype none

package ile_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 7;
  // fill counter holds 0..CAPACITY
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  // common width for position / index / fill compares
  localparam int unsigned CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_REMOVE    = 3'd2,
    ACT_READ      = 3'd3,
    ACT_OVERWRITE = 3'd4,
    ACT_FIND      = 3'd5
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } fsm_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_OUT_W-1:0]    count;
    logic                    is_empty;
  } res_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [CMP_W-1:0] idx;
    logic [CMP_W-1:0] fill;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/ile_cell.sv]
// One storage cell of the list chain: holds one entry, shifts with its neighbours.
// Depends on ile_pkg.
`default_nettype none

module ile_cell (
  input  logic                      clk_i,
  input  logic [ile_pkg::CMP_W-1:0] pos_i,
  input  ile_pkg::cell_ctl_t        ctl_i,
  input  logic [ile_pkg::VAL_W-1:0] lower_i,
  input  logic [ile_pkg::VAL_W-1:0] upper_i,
  output logic [ile_pkg::VAL_W-1:0] data_o,
  output logic                      match_o,
  output logic [ile_pkg::VAL_W-1:0] rd_o
);

  logic [ile_pkg::VAL_W-1:0] data_q, data_d;
  logic                      at_idx;
  logic                      live;

  assign at_idx = (pos_i == ctl_i.idx);
  assign live   = (pos_i < ctl_i.fill);

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      ile_pkg::CELL_APPEND: begin
        if (pos_i == ctl_i.fill) data_d = ctl_i.value;
      end
      ile_pkg::CELL_INSERT: begin
        if (at_idx) begin
          data_d = ctl_i.value;
        end else if ((pos_i > ctl_i.idx) && (pos_i <= ctl_i.fill)) begin
          data_d = lower_i;
        end
      end
      ile_pkg::CELL_REMOVE: begin
        if ((pos_i >= ctl_i.idx) && ((pos_i + 1'b1) < ctl_i.fill)) data_d = upper_i;
      end
      ile_pkg::CELL_WRITE: begin
        if (at_idx) data_d = ctl_i.value;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = live && (data_q == ctl_i.value);
  assign rd_o    = at_idx ? data_q : '0;

endmodule

`default_nettype wire

[rtl/indexed_list_engine.sv]
// Top level of the indexed list engine: command FSM, fill counter, cell chain.
// Depends on ile_pkg and ile_cell.
`default_nettype none

// Ordered list of signed 32-bit values, CAPACITY entries held in a row of
// cells, one entry per cell. A command beat is taken when start is high and
// busy is low. For each command, in the execute cycle (busy
// high) all cells shift, write and compare in parallel; in the following cycle
// the result is shown on res_o with done_o high for exactly that one cycle. The
// receiver cannot stall, so the result must be captured then. A new command
// can be taken in the same cycle that a result is shown; each command passes
// through the execute cycle of the cell chain followed by the registered
// first-match search; none is taken while busy. Status: ok, index out of
// range (index at or beyond count; insert also refuses index equal to count),
// list full (checked before the index on insert), value not found. read_value
// and found_index are zero unless a read or a find succeeds. Entries hold no
// reset value; the list starts empty and only entries below count are ever
// read, so no clearing pass is needed after reset.
module indexed_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ile_pkg::cmd_t in_i,
  output logic          busy,
  output logic          done_o,
  output ile_pkg::res_t res_o
);

  localparam int unsigned N = ile_pkg::CAPACITY;

  ile_pkg::fsm_e              state_q, state_d;
  ile_pkg::cmd_t              cmd_q;
  logic [ile_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic [ile_pkg::ST_W-1:0]   status_q, status_d;
  logic [ile_pkg::VAL_W-1:0]  read_q, read_d;
  logic [N-1:0]               match_q, match_d;

  logic                       accept;
  logic                       exec;
  logic                       full;
  logic                       in_range;
  logic [ile_pkg::CMP_W-1:0]  idx_ext;
  ile_pkg::cell_ctl_t         ctl;
  ile_pkg::cell_op_e          op;

  logic [ile_pkg::VAL_W-1:0]  cell_data [N];
  logic [ile_pkg::VAL_W-1:0]  cell_rd   [N];
  logic [N-1:0]               cell_match;
  logic [ile_pkg::VAL_W-1:0]  rd_or;
  logic [ile_pkg::IDX_W-1:0]  found;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ile_pkg::S_IDLE: if (start) state_d = ile_pkg::S_EXEC;
      ile_pkg::S_EXEC: state_d = ile_pkg::S_DONE;
      ile_pkg::S_DONE: state_d = start ? ile_pkg::S_EXEC : ile_pkg::S_IDLE;
      default:         state_d = ile_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    exec   = 1'b0;
    done_o = 1'b0;
    case (state_q)
      ile_pkg::S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      ile_pkg::S_DONE: done_o = 1'b1;
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ile_pkg::S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // command beat, payload only
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= in_i;
  end

  // ---------------------------------------------------------- execute decode
  assign full     = (fill_q == ile_pkg::CNT_W'(N));
  assign idx_ext  = ile_pkg::CMP_W'(cmd_q.index);
  assign in_range = (idx_ext < ile_pkg::CMP_W'(fill_q));

  always_comb begin
    op       = ile_pkg::CELL_HOLD;
    fill_d   = fill_q;
    status_d = ile_pkg::ST_OK;
    read_d   = '0;
    match_d  = '0;
    if (exec) begin
      case (cmd_q.action)
        ile_pkg::ACT_APPEND: begin
          if (full) begin
            status_d = ile_pkg::ST_FULL;
          end else begin
            op     = ile_pkg::CELL_APPEND;
            fill_d = fill_q + 1'b1;
          end
        end
        ile_pkg::ACT_INSERT: begin
          if (full) begin
            status_d = ile_pkg::ST_FULL;
          end else if (!in_range) begin
            status_d = ile_pkg::ST_RANGE;
          end else begin
            op     = ile_pkg::CELL_INSERT;
            fill_d = fill_q + 1'b1;
          end
        end
        ile_pkg::ACT_REMOVE: begin
          if (!in_range) begin
            status_d = ile_pkg::ST_RANGE;
          end else begin
            op     = ile_pkg::CELL_REMOVE;
            fill_d = fill_q - 1'b1;
          end
        end
        ile_pkg::ACT_READ: begin
          if (!in_range) status_d = ile_pkg::ST_RANGE;
          else           read_d   = rd_or;
        end
        ile_pkg::ACT_OVERWRITE: begin
          if (!in_range) status_d = ile_pkg::ST_RANGE;
          else           op       = ile_pkg::CELL_WRITE;
        end
        ile_pkg::ACT_FIND: begin
          match_d  = cell_match;
          status_d = (|cell_match) ? ile_pkg::ST_OK : ile_pkg::ST_NOTFOUND;
        end
        default: begin
          // unused codes: no change, status ok
          status_d = ile_pkg::ST_OK;
        end
      endcase
    end
  end

  // result registers, loaded in the execute cycle
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      read_q   <= read_d;
      match_q  <= match_d;
    end
  end

  // ---------------------------------------------------------- cell chain
  assign ctl.op    = op;
  assign ctl.idx   = idx_ext;
  assign ctl.fill  = ile_pkg::CMP_W'(fill_q);
  assign ctl.value = cmd_q.value;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ile_pkg::VAL_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    ile_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (ile_pkg::CMP_W'(i)),
      .ctl_i   (ctl),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // only the addressed cell drives a non-zero read word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < N; i++) rd_or = rd_or | cell_rd[i];
  end

  // first match, lowest position wins
  always_comb begin
    found = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_q[i]) found = ile_pkg::IDX_W'(i);
    end
  end

  // ---------------------------------------------------------- result beat
  assign res_o.status      = status_q;
  assign res_o.read_value  = read_q;
  assign res_o.found_index = found;
  assign res_o.count       = ile_pkg::CNT_OUT_W'(fill_q);
  assign res_o.is_empty    = (fill_q == '0);

  // ---------------------------------------------------------- assertions
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not enter execute");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("execute not followed by a result beat");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ile_pkg::CNT_W'(N))
    else $error("fill count beyond capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == ile_pkg::ST_FULL)) |-> full)
    else $error("full status with list not full");

endmodule

`default_nettype wire
